[rtl/radar_detection_gate_to_cartesian_macros.svh]
// Assertion helpers for the RTL top module.
`ifndef RADAR_DETECTION_GATE_TO_CARTESIAN_MACROS_SVH
`define RADAR_DETECTION_GATE_TO_CARTESIAN_MACROS_SVH

// Condition in the same cycle.
`define RDGC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Condition in the following cycle.
`define RDGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rdgc_pkg.sv]
package rdgc_pkg;

  localparam int CordicStages = 16;
  localparam int TableLen     = 24;
  localparam int NumIter      = (CordicStages < TableLen) ? CordicStages : TableLen;
  // prep stage, iterations, sign fix-up stage
  localparam int CordicLat    = NumIter + 2;

  localparam int AngleW = 34;
  localparam int XyW    = 33;
  localparam int TW     = 20;
  localparam int PW     = 23;
  localparam int OutW   = 17;

  localparam logic [15:0] RangeMin  = 16'd64;
  localparam logic [16:0] ElLimit   = 17'd6433;
  localparam logic [16:0] RateLimit = 17'd12800;
  localparam logic signed [15:0] SnrMin = 16'sd768;

  localparam logic signed [XyW-1:0]    GainQ30   = 33'sd652032874;
  localparam logic signed [AngleW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngleW-1:0] HalfPiQ30 = 34'sd1686629713;

  localparam logic signed [PW-1:0] OutMax = 23'sd65535;
  localparam logic signed [PW-1:0] OutMin = -23'sd65536;

  typedef struct packed {
    logic [15:0] range_lim;
    logic [14:0] az_lim;
  } cfg_t;

  function automatic logic signed [AngleW-1:0] atan_q30(input int idx);
    logic signed [AngleW-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      default: v = 34'sd128;
    endcase
    return v;
  endfunction

  function automatic logic signed [OutW-1:0] sat17(input logic signed [PW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > OutMax) r = OutMax[OutW-1:0];
    else if (v < OutMin) r = OutMin[OutW-1:0];
    else r = v[OutW-1:0];
    return r;
  endfunction

endpackage

[rtl/rdgc_gate.sv]
module rdgc_gate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [15:0]         range_i,
  input  logic signed [15:0]  azimuth_i,
  input  logic signed [15:0]  elevation_i,
  input  logic signed [15:0]  doppler_i,
  input  logic signed [15:0]  snr_i,
  input  rdgc_pkg::cfg_t      cfg_i,
  output logic                valid_o,
  output logic [15:0]         range_o,
  output logic signed [15:0]  azimuth_o,
  output logic signed [15:0]  elevation_o
);
  import rdgc_pkg::*;

  logic        valid_q;
  logic [15:0] range_q;
  logic signed [15:0] az_q, el_q;
  logic [16:0] az_abs, el_abs, rate_abs;
  logic        pass;

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  assign az_abs   = abs17(azimuth_i);
  assign el_abs   = abs17(elevation_i);
  assign rate_abs = abs17(doppler_i);

  assign pass = (range_i >= RangeMin) && (range_i <= cfg_i.range_lim)
             && (az_abs <= {2'b00, cfg_i.az_lim})
             && (el_abs <= ElLimit) && (rate_abs <= RateLimit)
             && (snr_i >= SnrMin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      range_q <= range_i;
      az_q    <= azimuth_i;
      el_q    <= elevation_i;
    end
  end

  assign valid_o     = valid_q;
  assign range_o     = range_q;
  assign azimuth_o   = az_q;
  assign elevation_o = el_q;
endmodule

[rtl/rdgc_cordic.sv]
module rdgc_cordic (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [15:0]              angle_i,
  output logic signed [rdgc_pkg::XyW-1:0] cos_o,
  output logic signed [rdgc_pkg::XyW-1:0] sin_o
);
  import rdgc_pkg::*;

  logic signed [AngleW-1:0] z_q [0:NumIter];
  logic signed [XyW-1:0]    x_q [0:NumIter];
  logic signed [XyW-1:0]    y_q [0:NumIter];
  logic                     flip_q [0:NumIter];
  logic signed [XyW-1:0]    cos_q, sin_q;
  logic signed [AngleW-1:0] z_in;

  assign z_in = {angle_i[15], angle_i, 17'b0};

  // fold into +-pi/2, sign restored at the end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GainQ30;
      y_q[0] <= '0;
      if (z_in > HalfPiQ30) begin
        z_q[0]    <= z_in - PiQ30;
        flip_q[0] <= 1'b1;
      end else if (z_in < -HalfPiQ30) begin
        z_q[0]    <= z_in + PiQ30;
        flip_q[0] <= 1'b1;
      end else begin
        z_q[0]    <= z_in;
        flip_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NumIter; i++) begin : g_iter
    logic signed [XyW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][AngleW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= flip_q[NumIter] ? -x_q[NumIter] : x_q[NumIter];
      sin_q <= flip_q[NumIter] ? -y_q[NumIter] : y_q[NumIter];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;
endmodule

[rtl/rdgc_proj.sv]
module rdgc_proj (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [15:0]                      range_i,
  input  logic signed [rdgc_pkg::XyW-1:0]  cos_az_i,
  input  logic signed [rdgc_pkg::XyW-1:0]  sin_az_i,
  input  logic signed [rdgc_pkg::XyW-1:0]  cos_el_i,
  input  logic signed [rdgc_pkg::XyW-1:0]  sin_el_i,
  output logic signed [rdgc_pkg::OutW-1:0] pos_x_o,
  output logic signed [rdgc_pkg::OutW-1:0] pos_y_o,
  output logic signed [rdgc_pkg::OutW-1:0] pos_z_o
);
  import rdgc_pkg::*;

  logic signed [16:0]         r_s;
  logic signed [49:0]         rc_prod, rs_prod;
  logic signed [TW-1:0]       t_q, pz_q;
  logic signed [XyW-1:0]      ca_q, sa_q;
  logic signed [TW+XyW-1:0]   xp, yp;
  logic signed [PW-1:0]       px_q, py_q, pz2_q;

  assign r_s     = signed'({1'b0, range_i});
  assign rc_prod = r_s * cos_el_i;
  assign rs_prod = r_s * sin_el_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= rc_prod[49:30];
      pz_q <= rs_prod[49:30];
      ca_q <= cos_az_i;
      sa_q <= sin_az_i;
    end
  end

  assign xp = t_q * ca_q;
  assign yp = t_q * sa_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= xp[TW+XyW-1:30];
      py_q  <= yp[TW+XyW-1:30];
      pz2_q <= PW'(pz_q);
    end
  end

  assign pos_x_o = sat17(px_q);
  assign pos_y_o = sat17(py_q);
  assign pos_z_o = sat17(pz2_q);
endmodule

[rtl/radar_detection_gate_to_cartesian.sv]
// Radar detection gate and polar-to-Cartesian converter.
// Input channel: in_valid_i / in_stall_o with range, azimuth, elevation,
// Doppler rate and SNR. A transfer happens when valid is high and stall low.
// Detections failing a gate are dropped; the rest give one output transfer
// with pos_x/pos_y/pos_z on out_valid_o / out_stall_i.
// Throughput: one detection per cycle while the output is not stalled.
// out_valid_o rises once the input transfer has passed the gate register
// (loaded at the transfer edge), CORDIC fold, one register per CORDIC
// iteration, sign fix-up, two multiply stages and the output register.
// Stalling the output while a result waits freezes every stage, bubbles
// included; in_stall_o then rises, nothing is lost or repeated.
// Reset clears every valid bit and restores the range limit to 200 m and
// the azimuth limit to pi/3. Registers at APB byte addresses 0 (range limit)
// and 4 (azimuth limit); write them only while the block is idle.
module radar_detection_gate_to_cartesian (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [15:0]  range_i,
  input  logic signed [15:0] azimuth_i,
  input  logic signed [15:0] elevation_i,
  input  logic signed [15:0] doppler_i,
  input  logic signed [15:0] snr_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o
);
  import rdgc_pkg::*;
  `include "radar_detection_gate_to_cartesian_macros.svh"

  localparam int VLen = CordicLat + 2;

  cfg_t cfg_q;
  logic adv, cfg_wr;
  logic g_valid;
  logic [15:0] g_range;
  logic signed [15:0] g_az, g_el;
  logic signed [XyW-1:0] ca, sa, ce, se;
  logic signed [OutW-1:0] px, py, pz;
  logic        v_q [0:VLen-1];
  logic [15:0] r_q [0:CordicLat-1];
  logic        out_valid_q;
  logic signed [OutW-1:0] px_q, py_q, pz_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_lim <= 16'd25600;
      cfg_q.az_lim    <= 15'd8579;
    end else if (cfg_wr) begin
      if (!paddr[2]) cfg_q.range_lim <= pwdata[15:0];
      else           cfg_q.az_lim    <= pwdata[14:0];
    end
  end

  assign prdata = paddr[2] ? {17'b0, cfg_q.az_lim} : {16'b0, cfg_q.range_lim};

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  rdgc_gate u_gate (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i),
    .range_i, .azimuth_i, .elevation_i, .doppler_i, .snr_i,
    .cfg_i(cfg_q), .valid_o(g_valid), .range_o(g_range),
    .azimuth_o(g_az), .elevation_o(g_el)
  );

  rdgc_cordic u_cordic_az (
    .clk_i, .en_i(adv), .angle_i(g_az), .cos_o(ca), .sin_o(sa)
  );

  rdgc_cordic u_cordic_el (
    .clk_i, .en_i(adv), .angle_i(g_el), .cos_o(ce), .sin_o(se)
  );

  // range and valid travel alongside the CORDIC lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VLen; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= g_valid;
      for (int i = 1; i < VLen; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0] <= g_range;
      for (int i = 1; i < CordicLat; i++) r_q[i] <= r_q[i-1];
    end
  end

  rdgc_proj u_proj (
    .clk_i, .en_i(adv), .range_i(r_q[CordicLat-1]),
    .cos_az_i(ca), .sin_az_i(sa), .cos_el_i(ce), .sin_el_i(se),
    .pos_x_o(px), .pos_y_o(py), .pos_z_o(pz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_q[VLen-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= px;
      py_q <= py;
      pz_q <= pz;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign pos_z_o     = pz_q;

  `RDGC_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o,
                    out_valid_o && out_stall_i, "input stalled without a held result")
  `RDGC_ASSERT_NEXT(a_cfg_range, clk_i, rst_ni, cfg_wr && !paddr[2],
                    cfg_q.range_lim == $past(pwdata[15:0]), "range limit write lost")
  `RDGC_ASSERT_NEXT(a_gate_drop, clk_i, rst_ni, adv && in_valid_i && (snr_i < SnrMin),
                    !g_valid, "low SNR detection passed the gate")
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import rdgc_pkg::*;

  localparam int TimeoutCycles = 400000;
  localparam int DrainCycles   = 40;
  localparam logic [2:0] AddrRangeLim = 3'd0;
  localparam logic [2:0] AddrAzLim    = 3'd4;

  typedef struct packed {
    logic [15:0] range;
    logic signed [15:0] azimuth;
    logic signed [15:0] elevation;
    logic signed [15:0] doppler;
    logic signed [15:0] snr;
  } detection_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } position_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  detection_t drv = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;

  radar_detection_gate_to_cartesian dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .range_i(drv.range), .azimuth_i(drv.azimuth), .elevation_i(drv.elevation),
    .doppler_i(drv.doppler), .snr_i(drv.snr),
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .pos_z_o
  );

  always #2 clk_i = ~clk_i;

  detection_t pending_dets[$];
  position_t  expected_pos[$];
  logic [15:0] gate_range_lim = 16'd25600;
  logic [14:0] gate_az_lim    = 15'd8579;
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  bit sender_paused = 1'b0;
  bit in_taken = 1'b0;
  int burst_left = 0, gap_left = 0;

  localparam longint AtanTab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  // >>> on longint is a floor shift
  function automatic void cordic_sincos(input int ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < NumIter; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [16:0] clamp17(input longint v);
    if (v > 65535) return 17'sd65535;
    if (v < -65536) return 17'sh10000;
    return v[16:0];
  endfunction

  function automatic void predict_position(input detection_t d);
    int az, el, rate, snr;
    longint ca, sa, ce, se, t;
    position_t p;
    az = d.azimuth; el = d.elevation; rate = d.doppler; snr = d.snr;
    if (d.range < 64 || d.range > gate_range_lim) return;
    if ((az < 0 ? -az : az) > int'(gate_az_lim)) return;
    if ((el < 0 ? -el : el) > 6433) return;
    if ((rate < 0 ? -rate : rate) > 12800) return;
    if (snr < 768) return;
    cordic_sincos(az, ca, sa);
    cordic_sincos(el, ce, se);
    t = (longint'(d.range) * ce) >>> 30;
    p.x = clamp17((t * ca) >>> 30);
    p.y = clamp17((t * sa) >>> 30);
    p.z = clamp17((longint'(d.range) * se) >>> 30);
    expected_pos = {expected_pos, p};
  endfunction

  // sender: bursts and gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // stalled: payload held
      end else begin
        if (in_taken) begin
          void'(pending_dets.pop_front());
          in_taken = 1'b0;
        end
        if (pending_dets.size() > 0 && !sender_paused && gap_left == 0) begin
          drv <= pending_dets[0];
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall_i <= 1'b1;
    end else begin
      case (($urandom_range(0, 3) + cycles / 512) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    position_t want;
    cycles++;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      in_taken = 1'b1;
      predict_position(drv);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer x=%0d y=%0d z=%0d",
                                       pos_x_o, pos_y_o, pos_z_o);
      end else begin
        want = expected_pos.pop_front();
        if (want.x !== pos_x_o || want.y !== pos_y_o || want.z !== pos_z_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("position mismatch: exp %0d %0d %0d got %0d %0d %0d",
                     want.x, want.y, want.z, pos_x_o, pos_y_o, pos_z_o);
        end
      end
    end
    if (cycles > TimeoutCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrRangeLim) gate_range_lim = data[15:0];
    else if (addr == AddrAzLim) gate_az_lim = data[14:0];
  endtask

  task automatic wait_idle();
    while (pending_dets.size() > 0 || expected_pos.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic detection_t random_detection(input bit plausible);
    detection_t d;
    if (plausible) begin
      d.range = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(40, 27000));
      d.azimuth = 16'($urandom_range(0, 2 * 25736) - 25736);
      if ($urandom_range(0, 1)) d.azimuth = 16'(int'($urandom_range(0, 9000)) - 4500);
      d.elevation = 16'(int'($urandom_range(0, 13500)) - 6750);
      d.doppler = 16'(int'($urandom_range(0, 27000)) - 13500);
      d.snr = 16'(int'($urandom_range(0, 8000)) - 500);
    end else begin
      d = detection_t'(80'({$urandom, $urandom, $urandom}));
    end
    return d;
  endfunction

  task automatic push(input int r, az, el, rate, snr);
    detection_t d;
    d.range = 16'(r); d.azimuth = 16'(az); d.elevation = 16'(el);
    d.doppler = 16'(rate); d.snr = 16'(snr);
    pending_dets = {pending_dets, d};
  endtask

  task automatic random_phase(input int n);
    repeat (n) pending_dets = {pending_dets, random_detection($urandom_range(0, 9) != 0)};
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: gate edges, quadrant fold, saturation
    push(64, 0, 0, 0, 768);
    push(63, 0, 0, 0, 768);
    push(25600, 0, 0, 0, 768);
    push(25601, 0, 0, 0, 768);
    push(1000, 8579, 0, 0, 1000);
    push(1000, -8579, 0, 0, 1000);
    push(1000, 8580, 0, 0, 1000);
    push(1000, 0, 6433, 0, 1000);
    push(1000, 0, -6433, 0, 1000);
    push(1000, 0, 6434, 0, 1000);
    push(1000, 0, 0, 12800, 1000);
    push(1000, 0, 0, -12800, 1000);
    push(1000, 0, 0, 12801, 1000);
    push(1000, 0, 0, 0, 767);
    push(1000, 0, 0, -32768, 32767);
    push(1000, 0, -32768, 0, 1000);
    wait_idle();
    apb_write(AddrRangeLim, 32'hFFFF_FFFF);
    apb_write(AddrAzLim, 32'd25736);
    push(65535, 25736, 0, 0, 32767);
    push(65535, -25736, 6433, 0, 1000);
    push(65535, 12868, 0, 0, 1000);
    push(65535, 20000, -6433, 0, 1000);
    push(65535, -15000, 3000, 0, 1000);
    push(40000, 25000, 100, 0, 1000);
    random_phase(150);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    random_phase(250);
    wait_idle();

    apb_write(AddrRangeLim, 32'd0);
    apb_write(AddrAzLim, 32'd0);
    push(64, 0, 0, 0, 1000);
    random_phase(50);
    wait_idle();

    apb_write(AddrRangeLim, 32'd25600);
    apb_write(AddrAzLim, 32'd8579);
    random_phase(250);
    // sender pauses until everything has drained
    while (pending_dets.size() > 0 || in_valid_i) @(posedge clk_i);
    sender_paused = 1'b1;
    while (expected_pos.size() > 0) @(posedge clk_i);
    sender_paused = 1'b0;

    apb_write(AddrRangeLim, 32'd12000);
    apb_write(AddrAzLim, 32'd20000);
    random_phase(300);
    wait_idle();

    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
